@@ hdl/nsf_pkg.sv @@
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared constants, codes and types of the NMEA sentence filter.
// ----------------------------------------------------------------------------
package nsf_pkg;

    localparam int DEF_LINE_DEPTH   = 256;
    localparam int DEF_HEADER_LIMIT = 16;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes.
    localparam int IN_W  = 24;
    localparam int OUT_W = 24;

    // Input item modes.
    localparam logic [1:0] MODE_RECV    = 2'd0;
    localparam logic [1:0] MODE_RD_RMC  = 2'd1;
    localparam logic [1:0] MODE_RD_GGA  = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    // Line outcome codes.
    localparam logic [1:0] OUT_NONE    = 2'd0;
    localparam logic [1:0] OUT_DROPPED = 2'd1;
    localparam logic [1:0] OUT_RMC     = 2'd2;
    localparam logic [1:0] OUT_GGA     = 2'd3;

    // Characters of interest.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;

    // A kept line is longer than this many bytes.
    localparam int MIN_LINE_LEN = 6;

    // Header status gathered while the line is received.
    typedef struct packed {
        logic dollar;      // first byte was '$'
        logic comma_seen;  // a comma has been received
        logic comma_ok;    // the first comma sits below the header limit
        logic rmc_hit;     // "RMC" seen before the first comma
        logic gga_hit;     // "GGA" seen before the first comma
    } t_hdr_stat;

endpackage

@@ hdl/nsf_mem.sv @@
// ----------------------------------------------------------------------------
// nsf_mem
// Byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module nsf_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/nsf_hdr_track.sv @@
// ----------------------------------------------------------------------------
// nsf_hdr_track
// Follows the header of the line being received, one byte at a time.
// ----------------------------------------------------------------------------
module nsf_hdr_track import nsf_pkg::*; #(
    parameter int HEADER_LIMIT = DEF_HEADER_LIMIT,
    parameter int LW           = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_push,
    input  logic [7:0]    i_byte,
    input  logic [LW-1:0] i_pos,
    output t_hdr_stat     o_stat
);

    t_hdr_stat  r_stat;
    logic [7:0] r_b1;
    logic [7:0] r_b2;
    logic       triple_ok;

    // A triple ending at this byte lies wholly inside the header.
    assign triple_ok = (i_pos >= LW'(2)) && !r_stat.comma_seen && (i_byte != CH_COMMA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_stat <= '0;
        end else if (i_push) begin
            if (i_pos == '0) begin
                r_stat.dollar <= (i_byte == CH_DOLLAR);
            end
            if (!r_stat.comma_seen && i_byte == CH_COMMA) begin
                r_stat.comma_seen <= 1'b1;
                r_stat.comma_ok   <= (32'(i_pos) < 32'(HEADER_LIMIT));
            end
            if (triple_ok && r_b2 == CH_R && r_b1 == CH_M && i_byte == CH_C) begin
                r_stat.rmc_hit <= 1'b1;
            end
            if (triple_ok && r_b2 == CH_G && r_b1 == CH_G && i_byte == CH_A) begin
                r_stat.gga_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_b2 <= r_b1;
            r_b1 <= i_byte;
        end
    end

    assign o_stat = r_stat;

endmodule

@@ hdl/nmea_sentence_filter.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_filter
// Collects received GPS bytes into lines and keeps RMC and GGA sentences.
// ----------------------------------------------------------------------------
// The block takes one item at a time on the slave stream and returns exactly
// one result item on the master stream for each. An item either delivers a
// received byte, reads one byte of the RMC or GGA slot, or releases slots.
// Received bytes go into a line store while a header tracker watches the
// leading '$', the first comma and the RMC or GGA tag. When a newline ends a
// well-formed sentence whose slot is free, a small sequencer copies the line
// into that slot one byte per cycle through the line store's read port.
// An ordinary byte or a release goes straight to the finish state, a slot
// read passes through the read state first, and a newline that stores a line
// runs the byte-wide copy loop first. The block is ready again once the
// result is loaded, and it is not ready while an item is in work.
// A result waits in an output register; the next item may be accepted while
// it waits, but its own result is held back until the receiver has taken the
// earlier one, so a stalled receiver stops the block after one further item.
// Reset clears the line count, the slot lengths and full flags and the
// output valid; the byte stores hold no defined contents until written.
// ----------------------------------------------------------------------------
module nmea_sentence_filter import nsf_pkg::*; #(
    parameter int LINE_DEPTH   = DEF_LINE_DEPTH,
    parameter int HEADER_LIMIT = DEF_HEADER_LIMIT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input item: mode[1:0], data_byte[9:2], read_index[17:10], zero pad.
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,
    // Result: line_outcome[1:0], overflowed[2], read_data[10:3],
    // stored_length[18:11], rmc_ready[19], gga_ready[20], zero pad.
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam int LW = $clog2(LINE_DEPTH);
    localparam int CW = (LW > 8) ? LW : 8;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_COPY   = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;

    // Line store bookkeeping.
    logic [LW-1:0] r_count;

    // Copy loop: issue index, line length, and the write stage behind the read.
    logic [LW-1:0] r_ci;
    logic [LW-1:0] r_n;
    logic          r_wv;
    logic [LW-1:0] r_wa;
    logic          r_tgt_rmc;

    // Slot state.
    logic          r_rmc_full;
    logic          r_gga_full;
    logic [LW-1:0] r_rmc_len;
    logic [LW-1:0] r_gga_len;

    // Read request.
    logic          r_rd_gga;
    logic [7:0]    r_idx;

    // Result in work and the output register.
    logic [1:0]    r_p_outcome;
    logic          r_p_ovf;
    logic [7:0]    r_p_rdata;
    logic [7:0]    r_p_slen;
    logic          r_m_valid;
    logic [OUT_W-1:0] r_m_data;

    // Unpacked input fields.
    logic [1:0]    in_mode;
    logic [7:0]    in_byte;
    logic [7:0]    in_idx;

    logic          accept;
    logic          recv;
    logic          full_line;
    logic          push;
    logic          eol;
    logic          hdr_ok;
    logic          to_rmc;
    logic          to_gga;
    logic          out_free;
    t_hdr_stat     hdr_stat;

    logic [7:0]    line_q;
    logic [7:0]    rmc_q;
    logic [7:0]    gga_q;
    logic          rmc_we;
    logic          gga_we;
    logic [LW-1:0] slot_raddr;
    logic [LW-1:0] sel_len;
    logic [7:0]    sel_q;

    assign in_mode = i_s_tdata[1:0];
    assign in_byte = i_s_tdata[9:2];
    assign in_idx  = i_s_tdata[17:10];

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign recv       = accept && (in_mode == MODE_RECV);

    // A store that already holds LINE_DEPTH-1 bytes restarts and drops the byte.
    assign full_line = (r_count >= LW'(LINE_DEPTH - 1));
    assign push      = recv && !full_line;
    assign eol       = push && (in_byte == CH_NL);

    // The newline itself cannot change the header status, so the status from
    // the earlier bytes decides the line.
    assign hdr_ok = hdr_stat.dollar && hdr_stat.comma_seen && hdr_stat.comma_ok &&
                    (r_count >= LW'(MIN_LINE_LEN));
    assign to_rmc = hdr_ok && hdr_stat.rmc_hit && !r_rmc_full;
    assign to_gga = hdr_ok && !hdr_stat.rmc_hit && hdr_stat.gga_hit && !r_gga_full;

    assign out_free = !r_m_valid || i_m_tready;

    nsf_hdr_track #(
        .HEADER_LIMIT (HEADER_LIMIT),
        .LW           (LW)
    ) u_hdr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (eol || (recv && full_line)),
        .i_push  (push),
        .i_byte  (in_byte),
        .i_pos   (r_count),
        .o_stat  (hdr_stat)
    );

    nsf_mem #(
        .DEPTH (LINE_DEPTH),
        .AW    (LW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_count),
        .i_wdata (in_byte),
        .i_raddr (r_ci),
        .o_rdata (line_q)
    );

    // Slots are read at the index of the accepted item; the data is ready in
    // the following cycle.
    assign slot_raddr = LW'(in_idx);
    assign rmc_we     = (r_state == ST_COPY) && r_wv && r_tgt_rmc;
    assign gga_we     = (r_state == ST_COPY) && r_wv && !r_tgt_rmc;

    nsf_mem #(
        .DEPTH (LINE_DEPTH),
        .AW    (LW)
    ) u_rmc (
        .i_clk   (i_clk),
        .i_we    (rmc_we),
        .i_waddr (r_wa),
        .i_wdata (line_q),
        .i_raddr (slot_raddr),
        .o_rdata (rmc_q)
    );

    nsf_mem #(
        .DEPTH (LINE_DEPTH),
        .AW    (LW)
    ) u_gga (
        .i_clk   (i_clk),
        .i_we    (gga_we),
        .i_waddr (r_wa),
        .i_wdata (line_q),
        .i_raddr (slot_raddr),
        .o_rdata (gga_q)
    );

    assign sel_len = r_rd_gga ? r_gga_len : r_rmc_len;
    assign sel_q   = r_rd_gga ? gga_q : rmc_q;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_mode)
                        MODE_RECV: begin
                            n_state = (eol && (to_rmc || to_gga)) ? ST_COPY : ST_FINISH;
                        end
                        MODE_RD_RMC, MODE_RD_GGA: begin
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_COPY: begin
                if (r_ci == r_n) begin
                    n_state = ST_FINISH;
                end
            end
            ST_READ: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_wv       <= 1'b0;
            r_rmc_full <= 1'b0;
            r_gga_full <= 1'b0;
            r_rmc_len  <= '0;
            r_gga_len  <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_wv <= 1'b0;
                    if (accept) begin
                        case (in_mode)
                            MODE_RECV: begin
                                if (full_line || eol) begin
                                    r_count <= '0;
                                end else begin
                                    r_count <= r_count + LW'(1);
                                end
                                if (eol && to_rmc) begin
                                    r_rmc_full <= 1'b1;
                                    r_rmc_len  <= r_count + LW'(1);
                                end
                                if (eol && to_gga) begin
                                    r_gga_full <= 1'b1;
                                    r_gga_len  <= r_count + LW'(1);
                                end
                            end
                            MODE_RELEASE: begin
                                if (in_byte[0]) begin
                                    r_rmc_full <= 1'b0;
                                end
                                if (in_byte[1]) begin
                                    r_gga_full <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_COPY: begin
                    r_wv <= (r_ci != r_n);
                end
                default: begin
                    r_wv <= 1'b0;
                end
            endcase

            if (r_state == ST_FINISH && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_p_outcome <= OUT_NONE;
                    r_p_ovf     <= 1'b0;
                    r_p_rdata   <= '0;
                    r_p_slen    <= '0;
                    r_rd_gga    <= (in_mode == MODE_RD_GGA);
                    r_idx       <= in_idx;
                    r_ci        <= '0;
                    r_n         <= r_count + LW'(1);
                    r_tgt_rmc   <= to_rmc;
                    if (recv && full_line) begin
                        r_p_ovf <= 1'b1;
                    end
                    if (eol) begin
                        if (to_rmc) begin
                            r_p_outcome <= OUT_RMC;
                        end else if (to_gga) begin
                            r_p_outcome <= OUT_GGA;
                        end else begin
                            r_p_outcome <= OUT_DROPPED;
                        end
                    end
                end
            end
            ST_COPY: begin
                // Issue the next read; the byte is written to the slot in the cycle after.
                if (r_ci != r_n) begin
                    r_ci <= r_ci + LW'(1);
                    r_wa <= r_ci;
                end
            end
            ST_READ: begin
                r_p_slen  <= 8'(sel_len);
                r_p_rdata <= (CW'(r_idx) < CW'(sel_len)) ? sel_q : 8'd0;
            end
            default: begin
            end
        endcase

        if (r_state == ST_FINISH && out_free) begin
            r_m_data <= {3'b000, r_gga_full, r_rmc_full, r_p_slen, r_p_rdata,
                         r_p_ovf, r_p_outcome};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

@@ tb/nmea_sentence_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_filter_tb
// Self-checking regression for the NMEA sentence filter.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a clocked driver on the input stream. A
// clocked monitor takes the result stream. Each accepted item runs through
// a predictor that keeps its own copy of the line store and of both slots.
// The predicted result is queued, and every result the block returns is
// compared field by field with the oldest prediction. The stimulus starts
// with a few directed items. Most of the random part is well-formed
// sentences with random headers and bodies. The rest is slot reads,
// releases, broken lines, noise bytes and a few lines at or past full size.
// Both stream sides idle at random, and once the receiver holds off for a
// long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module nmea_sentence_filter_tb;
    import nsf_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 8;
    localparam int ITEM_TARGET  = 1500;
    // The slowest item is the newline of a stored line of 255 bytes.
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int GIANT_RUNS   = 4;

    // Header tag choices for generated sentences.
    localparam logic [1:0] TAG_NONE = 2'd0;
    localparam logic [1:0] TAG_RMC  = 2'd1;
    localparam logic [1:0] TAG_GGA  = 2'd2;
    localparam logic [1:0] TAG_BOTH = 2'd3;

    // Release masks: bit 0 frees the RMC slot, bit 1 the GGA slot.
    localparam logic [7:0] FREE_NONE = 8'h00;
    localparam logic [7:0] FREE_BOTH = 8'h03;
    localparam logic [7:0] FREE_ALL  = 8'hFF;

    localparam logic [7:0] LETTER_Z   = 8'h5A;
    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7E;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    // One input item; the last field sits in the lowest bits.
    typedef struct packed {
        logic [7:0] read_index;
        logic [7:0] data_byte;
        logic [1:0] mode;
    } gps_item_t;

    // One result item; the last field sits in the lowest bits.
    typedef struct packed {
        logic       gga_ready;
        logic       rmc_ready;
        logic [7:0] stored_length;
        logic [7:0] read_data;
        logic       overflowed;
        logic [1:0] line_outcome;
    } filter_result_t;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    // Input item: mode[1:0], data_byte[9:2], read_index[17:10], zero pad.
    logic [IN_W-1:0]  i_s_tdata  = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    // Result: line_outcome[1:0], overflowed[2], read_data[10:3],
    // stored_length[18:11], rmc_ready[19], gga_ready[20], zero pad.
    logic [OUT_W-1:0] o_m_tdata;

    nmea_sentence_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: the line being collected and the two sentence slots.
    // ------------------------------------------------------------------------
    logic [7:0]  line_buf [DEF_LINE_DEPTH];
    logic [7:0]  rmc_copy [DEF_LINE_DEPTH];
    logic [7:0]  gga_copy [DEF_LINE_DEPTH];
    int unsigned line_fill = 0;
    int unsigned rmc_len   = 0;
    int unsigned gga_len   = 0;
    bit          rmc_taken = 1'b0;
    bit          gga_taken = 1'b0;

    gps_item_t      pending_items[$];
    filter_result_t awaited_results[$];
    int unsigned    items_queued = 0;
    int unsigned    results_seen = 0;
    int unsigned    mismatches   = 0;

    // Handshake flags sampled at the rising edge for the falling-edge drivers.
    logic item_taken   = 1'b0;
    logic result_taken = 1'b0;
    logic hold_output  = 1'b0;

    // True when the three bytes a, b, c appear in a row within the first
    // len bytes of the collected line.
    function automatic bit tag_before(int unsigned len, logic [7:0] a, logic [7:0] b,
                                      logic [7:0] c);
        for (int unsigned j = 0; j + 3 <= len; j++) begin
            if (line_buf[j] == a && line_buf[j+1] == b && line_buf[j+2] == c)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Judges the finished line and copies it into its slot when it is kept.
    // The RMC tag wins over GGA, and a busy RMC slot drops the line outright.
    function automatic logic [1:0] close_line();
        int unsigned n;
        int unsigned comma;
        n     = line_fill;
        comma = n;
        if (line_buf[0] != CH_DOLLAR || n <= MIN_LINE_LEN)
            return OUT_DROPPED;
        for (int unsigned j = 0; j < n; j++) begin
            if (line_buf[j] == CH_COMMA) begin
                comma = j;
                break;
            end
        end
        if (comma == n || comma >= DEF_HEADER_LIMIT)
            return OUT_DROPPED;
        if (tag_before(comma, CH_R, CH_M, CH_C)) begin
            if (rmc_taken)
                return OUT_DROPPED;
            for (int unsigned j = 0; j < n; j++)
                rmc_copy[j] = line_buf[j];
            rmc_len   = n;
            rmc_taken = 1'b1;
            return OUT_RMC;
        end
        if (tag_before(comma, CH_G, CH_G, CH_A)) begin
            if (gga_taken)
                return OUT_DROPPED;
            for (int unsigned j = 0; j < n; j++)
                gga_copy[j] = line_buf[j];
            gga_len   = n;
            gga_taken = 1'b1;
            return OUT_GGA;
        end
        return OUT_DROPPED;
    endfunction

    // Advances the predictor by one accepted item and returns its result.
    function automatic filter_result_t filter_step(gps_item_t it);
        filter_result_t r;
        r = '0;
        case (it.mode)
            MODE_RECV: begin
                // A full line store throws the line away, even on a newline.
                if (line_fill >= DEF_LINE_DEPTH - 1) begin
                    line_fill    = 0;
                    r.overflowed = 1'b1;
                end else begin
                    line_buf[line_fill] = it.data_byte;
                    line_fill++;
                    if (it.data_byte == CH_NL) begin
                        r.line_outcome = close_line();
                        line_fill      = 0;
                    end
                end
            end
            MODE_RD_RMC: begin
                r.stored_length = rmc_len[7:0];
                if (it.read_index < rmc_len)
                    r.read_data = rmc_copy[it.read_index];
            end
            MODE_RD_GGA: begin
                r.stored_length = gga_len[7:0];
                if (it.read_index < gga_len)
                    r.read_data = gga_copy[it.read_index];
            end
            default: begin
                // Release clears only the flags; slot contents stay readable.
                if (it.data_byte[0])
                    rmc_taken = 1'b0;
                if (it.data_byte[1])
                    gga_taken = 1'b0;
            end
        endcase
        r.rmc_ready = rmc_taken;
        r.gga_ready = gga_taken;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------------
    task automatic queue_item(logic [1:0] m, logic [7:0] b, logic [7:0] idx);
        gps_item_t it;
        it.mode       = m;
        it.data_byte  = b;
        it.read_index = idx;
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [7:0] random_letter();
        return 8'($urandom_range(CH_A, LETTER_Z));
    endfunction

    // Mostly printable text, now and then any byte; never a newline.
    function automatic logic [7:0] random_body_byte();
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0)
            b = 8'($urandom);
        else
            b = 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
        return (b == CH_NL) ? NUL_BYTE : b;
    endfunction

    // Sends lead, head_len-1 letters (with the chosen tags placed in them),
    // an optional comma, body_len body bytes and a newline.
    task automatic send_sentence(logic [7:0] lead, logic [1:0] tags, int unsigned head_len,
                                 int unsigned body_len, bit with_comma);
        logic [7:0]  draft[$];
        int unsigned at;
        draft.push_back(lead);
        repeat (head_len - 1) draft.push_back(random_letter());
        if (tags[0] && head_len >= 4) begin
            at = $urandom_range(1, head_len - 3);
            draft[at]   = CH_R;
            draft[at+1] = CH_M;
            draft[at+2] = CH_C;
        end
        // A GGA tag may land on top of the RMC one; the predictor sorts it out.
        if (tags[1] && head_len >= 4) begin
            at = $urandom_range(1, head_len - 3);
            draft[at]   = CH_G;
            draft[at+1] = CH_G;
            draft[at+2] = CH_A;
        end
        if (with_comma)
            draft.push_back(CH_COMMA);
        repeat (body_len) draft.push_back(random_body_byte());
        draft.push_back(CH_NL);
        foreach (draft[i])
            queue_item(MODE_RECV, draft[i], 8'($urandom));
    endtask

    task automatic queue_reads();
        logic [1:0] m;
        m = ($urandom_range(0, 1) == 0) ? MODE_RD_RMC : MODE_RD_GGA;
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 4) == 0)
                queue_item(m, 8'($urandom), 8'($urandom));
            else
                queue_item(m, 8'($urandom), 8'($urandom_range(0, 40)));
        end
    endtask

    // Lines that must never be stored, plus short ones at the length limit.
    task automatic send_broken();
        case ($urandom_range(0, 4))
            0: send_sentence(random_letter(), 2'($urandom_range(TAG_NONE, TAG_BOTH)),
                             $urandom_range(4, 12), $urandom_range(0, 20), 1'b1);
            1: send_sentence(CH_DOLLAR, TAG_RMC + 2'($urandom_range(0, 1)), 4,
                             $urandom_range(0, 1), 1'b1);
            2: send_sentence(CH_DOLLAR, 2'($urandom_range(TAG_NONE, TAG_BOTH)),
                             $urandom_range(1, 14), $urandom_range(0, 8), 1'b0);
            3: send_sentence(CH_DOLLAR, 2'($urandom_range(TAG_RMC, TAG_BOTH)),
                             $urandom_range(16, 20), $urandom_range(0, 20), 1'b1);
            default: queue_item(MODE_RECV, CH_NL, 8'($urandom));
        endcase
    endtask

    // A few raw bytes of any value; they may leave a partial line behind.
    task automatic send_noise();
        repeat ($urandom_range(1, 8)) queue_item(MODE_RECV, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 1) == 0)
            queue_item(MODE_RECV, CH_NL, 8'($urandom));
    endtask

    // Lines at and beyond the store's size. A 255-byte line fits exactly,
    // a 256-byte one loses its newline to the overflow, and a long run of
    // bytes with no newline wraps the store.
    task automatic send_giant(int unsigned kind);
        queue_item(MODE_RELEASE, FREE_BOTH, 8'($urandom));
        case (kind)
            0: send_sentence(CH_DOLLAR, TAG_RMC, 6, 247, 1'b1);
            1: send_sentence(CH_DOLLAR, TAG_GGA, 6, 248, 1'b1);
            2: begin
                repeat (300) queue_item(MODE_RECV, random_body_byte(), 8'($urandom));
                queue_item(MODE_RECV, CH_NL, 8'($urandom));
            end
            default: send_sentence(CH_DOLLAR, TAG_GGA, 6, 247, 1'b1);
        endcase
        for (int i = 250; i < 256; i++) begin
            queue_item(MODE_RD_RMC, 8'($urandom), 8'(i));
            queue_item(MODE_RD_GGA, 8'($urandom), 8'(i));
        end
    endtask

    task automatic fill_stimulus();
        int unsigned pick;
        int unsigned giants;
        giants = 0;

        // Directed: reads and releases before anything is stored, a lone
        // newline, a short RMC sentence read back across its end, and a
        // six-byte GGA line that is one byte too short to keep.
        queue_item(MODE_RD_RMC, FREE_NONE, 8'h00);
        queue_item(MODE_RD_GGA, FREE_ALL, 8'hFF);
        queue_item(MODE_RELEASE, FREE_NONE, 8'h00);
        queue_item(MODE_RELEASE, FREE_ALL, 8'hFF);
        queue_item(MODE_RECV, CH_NL, 8'h00);
        send_sentence(CH_DOLLAR, TAG_RMC, 6, 1, 1'b1);
        queue_item(MODE_RD_RMC, 8'h00, 8'd0);
        queue_item(MODE_RD_RMC, 8'h00, 8'd8);
        queue_item(MODE_RD_RMC, 8'h00, 8'd9);
        queue_item(MODE_RD_RMC, 8'h00, 8'hFF);
        send_sentence(CH_DOLLAR, TAG_GGA, 4, 0, 1'b1);

        // Random part, weighted toward complete sentences so that the slots
        // fill, get busy, and are freed again by releases.
        while (items_queued < ITEM_TARGET) begin
            if (giants < GIANT_RUNS && items_queued >= 200 + giants * 350) begin
                send_giant(giants);
                giants++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_sentence(CH_DOLLAR, 2'($urandom_range(TAG_NONE, TAG_BOTH)),
                              $urandom_range(4, 15), $urandom_range(0, 40), 1'b1);
            else if (pick < 62)
                queue_reads();
            else if (pick < 72)
                queue_item(MODE_RELEASE, 8'($urandom), 8'($urandom));
            else if (pick < 90)
                send_broken();
            else
                send_noise();
        end
    endtask

    // ------------------------------------------------------------------------
    // Idle pattern: each side runs in stretches, each drawn either calm, with no
    // idling, or busy, with a random idle gap before each item.
    // ------------------------------------------------------------------------
    function automatic int unsigned draw_wait(inout int unsigned phase, inout bit calm);
        if (phase == 0) begin
            calm  = ($urandom_range(0, 2) == 0);
            phase = $urandom_range(20, 80);
        end
        phase--;
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    int unsigned send_gap   = 0;
    int unsigned send_phase = 0;
    bit          send_calm  = 1'b0;
    int unsigned recv_stall = 0;
    int unsigned recv_phase = 0;
    bit          recv_calm  = 1'b0;

    // Driver: presents the next pending item on the falling edge once the
    // previous one was taken and its idle gap has passed.
    always @(negedge i_clk) begin
        logic next_valid;
        if (i_rst_n) begin
            next_valid = i_s_tvalid;
            if (item_taken) begin
                next_valid = 1'b0;
                send_gap   = draw_wait(send_phase, send_calm);
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    i_s_tdata  <= {{(IN_W - $bits(gps_item_t)){1'b0}}, pending_items.pop_front()};
                    next_valid = 1'b1;
                end
            end
            i_s_tvalid <= next_valid;
        end
    end

    // Receiver: stalls after each result for its drawn count, and stays
    // off entirely while the long hold is in force.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (result_taken)
                recv_stall = draw_wait(recv_phase, recv_calm);
            if (hold_output) begin
                i_m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // One long hold on the result side while the driver keeps offering.
    initial begin
        while (results_seen < HOLD_AFTER) @(posedge i_clk);
        hold_output = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_output = 1'b0;
    end

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result %0d field %s expected %0d got %0d",
                         $time, results_seen, field, want, got);
        end
    endtask

    // Monitor and scoreboard on the rising edge. The result is checked
    // before the new prediction is queued, so a result can never be matched
    // against an item accepted in the same cycle.
    always @(posedge i_clk) begin
        filter_result_t seen;
        filter_result_t want;
        item_taken   <= i_rst_n && i_s_tvalid && o_s_tready;
        result_taken <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen = filter_result_t'(o_m_tdata[$bits(filter_result_t)-1:0]);
            results_seen++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result %0d arrived with no item waiting: %h",
                             $time, results_seen, o_m_tdata);
            end else begin
                want = awaited_results.pop_front();
                check_field("line_outcome", want.line_outcome, seen.line_outcome);
                check_field("overflowed", want.overflowed, seen.overflowed);
                check_field("read_data", want.read_data, seen.read_data);
                check_field("stored_length", want.stored_length, seen.stored_length);
                check_field("rmc_ready", want.rmc_ready, seen.rmc_ready);
                check_field("gga_ready", want.gga_ready, seen.gga_ready);
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready)
            awaited_results.push_back(filter_step(gps_item_t'(i_s_tdata[$bits(gps_item_t)-1:0])));
    end

    // Main sequence: fill the item queue, release reset, then wait for the
    // stream to drain and for the block to settle before the verdict.
    initial begin
        fill_stimulus();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (pending_items.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (awaited_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("nmea_sentence_filter regression: pass");
        else
            $display("nmea_sentence_filter regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("nmea_sentence_filter regression: fail");
        $finish;
    end

endmodule
